[hw/rtl/scfa_pkg.sv]
// types and codes for the second-chance frame allocator
// no dependencies; used by second_chance_frame_allocator_unit
`default_nettype none
package scfa_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } state_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_REF   = 1'b1;

  localparam logic KIND_PAGE  = 1'b0;
  localparam logic KIND_TABLE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage
`default_nettype wire

[hw/rtl/second_chance_frame_allocator_unit.sv]
// second-chance (clock) physical frame allocator, one sequencer walking a frame store
// depends on scfa_pkg
`default_nettype none
// A beat is taken when start_i is high and busy_o is low; each beat yields one result,
// shown for exactly one cycle with result_valid_o, and the receiver cannot stall it.
// A reference, or an allocate while unused frames remain, needs no walk: its result
// appears the cycle after the beat and busy_o stays low. Frames are handed out in order,
// so a fill count stands in for the per-frame used bits and no clearing pass is needed
// after reset. Once every frame is in use the replacement order is frame order and only
// the head moves, so an allocate walks the frame store from the head, visiting each frame
// with a store read, then a compare and accessed-bit clear, for at most 2 * FRAME_COUNT
// frames, and reports a failure when no victim exists.
module second_chance_frame_allocator_unit #(
  parameter int FRAME_COUNT = 1024,
  parameter int OWNER_BITS  = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        operation_i,
  input  wire logic [9:0]  frame_index_i,
  input  wire logic        frame_kind_i,
  input  wire logic [5:0]  owner_id_i,
  input  wire logic [19:0] virtual_page_i,
  output logic             result_valid_o,
  output logic             status_o,
  output logic [9:0]       granted_frame_o,
  output logic             was_replaced_o,
  output logic [5:0]       old_owner_o,
  output logic [19:0]      old_page_o
);

  localparam int AW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int FW = $clog2(FRAME_COUNT + 1);
  localparam int SW = $clog2(2 * FRAME_COUNT);
  localparam logic [AW-1:0] LAST_FRAME = AW'(FRAME_COUNT - 1);
  localparam logic [FW-1:0] FULL_FILL  = FW'(FRAME_COUNT);
  localparam logic [SW-1:0] LAST_STEP  = SW'(2 * FRAME_COUNT - 1);

  // frame stores, no reset: only frames below the fill count are ever used
  logic                  kind_mem  [FRAME_COUNT];
  logic                  acc_mem   [FRAME_COUNT];
  logic [OWNER_BITS-1:0] owner_mem [FRAME_COUNT];
  logic [19:0]           page_mem  [FRAME_COUNT];

  scfa_pkg::state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [SW-1:0] steps_q, steps_d;

  logic                  kind_q;
  logic [OWNER_BITS-1:0] owner_q;
  logic [19:0]           page_q;

  logic                  rd_kind_q;
  logic                  rd_acc_q;
  logic [OWNER_BITS-1:0] rd_owner_q;
  logic [19:0]           rd_page_q;

  logic       vld_q, vld_d;
  logic       status_q, status_d;
  logic [9:0] granted_q, granted_d;
  logic       repl_q, repl_d;
  logic [5:0] oowner_q, oowner_d;
  logic [19:0] opage_q, opage_d;

  logic            acc_we, acc_wd, meta_we, meta_kind;
  logic [AW-1:0]   acc_addr, meta_addr;
  logic [OWNER_BITS-1:0] meta_owner;
  logic [19:0]     meta_page;
  logic            accept;

  logic [OWNER_BITS+5:0] owner_in_ext;
  logic [OWNER_BITS+5:0] owner_rd_ext;
  logic [AW+9:0]         idx_ext;
  logic [AW+9:0]         cur_ext;
  logic [AW+9:0]         fill_idx_ext;
  logic [FW+AW-1:0]      fill_ext;
  logic [31:0]           idx_w, fill_w;
  logic [AW-1:0]         cur_next;
  logic                  victim;

  assign owner_in_ext = {{OWNER_BITS{1'b0}}, owner_id_i};
  assign owner_rd_ext = {6'b0, rd_owner_q};
  assign idx_ext      = {{AW{1'b0}}, frame_index_i};
  assign cur_ext      = {10'b0, cur_q};
  assign fill_ext     = {{AW{1'b0}}, fill_q};
  assign fill_idx_ext = {10'b0, fill_ext[AW-1:0]};
  assign idx_w        = {22'b0, frame_index_i};
  assign fill_w       = 32'(fill_q);
  assign cur_next     = (cur_q == LAST_FRAME) ? '0 : cur_q + AW'(1);
  assign victim       = (rd_kind_q == scfa_pkg::KIND_PAGE) && !rd_acc_q;
  assign accept       = start_i && (state_q == scfa_pkg::ST_IDLE);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    head_d     = head_q;
    cur_d      = cur_q;
    steps_d    = steps_q;
    vld_d      = 1'b0;
    status_d   = scfa_pkg::STATUS_OK;
    granted_d  = '0;
    repl_d     = 1'b0;
    oowner_d   = '0;
    opage_d    = '0;
    acc_we     = 1'b0;
    acc_addr   = cur_q;
    acc_wd     = 1'b0;
    meta_we    = 1'b0;
    meta_addr  = cur_q;
    meta_kind  = kind_q;
    meta_owner = owner_q;
    meta_page  = page_q;
    case (state_q)
      scfa_pkg::ST_IDLE: begin
        if (accept) begin
          vld_d = 1'b1;
          if (operation_i == scfa_pkg::OP_REF) begin
            if (idx_w < FRAME_COUNT && idx_w < fill_w) begin
              acc_we   = 1'b1;
              acc_addr = idx_ext[AW-1:0];
              acc_wd   = 1'b1;
            end
          end else if (fill_q != FULL_FILL) begin
            // fresh frame joins the ring at the tail, which is frame order
            acc_we     = 1'b1;
            acc_addr   = fill_ext[AW-1:0];
            meta_we    = 1'b1;
            meta_addr  = fill_ext[AW-1:0];
            meta_kind  = frame_kind_i;
            meta_owner = owner_in_ext[OWNER_BITS-1:0];
            meta_page  = virtual_page_i;
            granted_d  = fill_idx_ext[9:0];
            fill_d     = fill_q + FW'(1);
          end else begin
            vld_d   = 1'b0;
            cur_d   = head_q;
            steps_d = '0;
            state_d = scfa_pkg::ST_READ;
          end
        end
      end
      scfa_pkg::ST_READ: begin
        state_d = scfa_pkg::ST_CHECK;
      end
      scfa_pkg::ST_CHECK: begin
        if (victim) begin
          // unlink plus re-append at the tail only moves the head past the victim
          acc_we    = 1'b1;
          meta_we   = 1'b1;
          vld_d     = 1'b1;
          granted_d = cur_ext[9:0];
          repl_d    = 1'b1;
          oowner_d  = owner_rd_ext[5:0];
          opage_d   = rd_page_q;
          head_d    = cur_next;
          state_d   = scfa_pkg::ST_IDLE;
        end else begin
          acc_we = 1'b1;
          if (steps_q == LAST_STEP) begin
            vld_d    = 1'b1;
            status_d = scfa_pkg::STATUS_FAIL;
            state_d  = scfa_pkg::ST_IDLE;
          end else begin
            steps_d = steps_q + SW'(1);
            cur_d   = cur_next;
            state_d = scfa_pkg::ST_READ;
          end
        end
      end
      default: state_d = scfa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scfa_pkg::ST_IDLE;
      fill_q  <= '0;
      head_q  <= '0;
      cur_q   <= '0;
      steps_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      head_q  <= head_d;
      cur_q   <= cur_d;
      steps_q <= steps_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    granted_q <= granted_d;
    repl_q    <= repl_d;
    oowner_q  <= oowner_d;
    opage_q   <= opage_d;
    if (accept) begin
      kind_q  <= frame_kind_i;
      owner_q <= owner_in_ext[OWNER_BITS-1:0];
      page_q  <= virtual_page_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_addr] <= acc_wd;
    rd_acc_q <= acc_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      kind_mem[meta_addr]  <= meta_kind;
      owner_mem[meta_addr] <= meta_owner;
      page_mem[meta_addr]  <= meta_page;
    end
    rd_kind_q  <= kind_mem[cur_q];
    rd_owner_q <= owner_mem[cur_q];
    rd_page_q  <= page_mem[cur_q];
  end

  assign busy_o          = (state_q != scfa_pkg::ST_IDLE);
  assign result_valid_o  = vld_q;
  assign status_o        = status_q;
  assign granted_frame_o = granted_q;
  assign was_replaced_o  = repl_q;
  assign old_owner_o     = oowner_q;
  assign old_page_o      = opage_q;

  // the walk only runs with every frame handed out
  a_walk_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != scfa_pkg::ST_IDLE) |-> (fill_q == FULL_FILL))
    else $error("ring walk with unused frames left");

  // a failed allocate reports nothing else
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && status_q == scfa_pkg::STATUS_FAIL) |-> (granted_q == '0 && !repl_q))
    else $error("failed allocate carries a frame");

  // a replacement advances the head just past the victim
  a_head_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scfa_pkg::ST_CHECK && victim) |=> (head_q == $past(cur_next)))
    else $error("head not past victim");

endmodule
`default_nettype wire
